// ----- rtl/core/lsdrs_pkg.sv -----
// Shared constants and the digit extraction function of the LSD radix sort unit.
package lsdrs_pkg;

   localparam int CAPACITY   = 64;
   localparam int KEY_BITS   = 32;
   localparam int DIGIT_BITS = 1;

   localparam int KEY_W  = 32;
   localparam int RADIX  = 1 << DIGIT_BITS;
   localparam int PASSES = (KEY_BITS + DIGIT_BITS - 1) / DIGIT_BITS;
   localparam int ADDR_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int PASS_W = $clog2(PASSES + 1);

   localparam logic [63:0] SORT_MASK =
      (KEY_BITS >= 64) ? {64{1'b1}} : ((64'd1 << KEY_BITS) - 64'd1);

   function automatic logic [DIGIT_BITS-1:0] digit_of(input logic [KEY_W-1:0] key,
                                                      input logic [PASS_W-1:0] pass);
      logic [63:0] masked;
      logic [63:0] shifted;
      int          shift;
      masked  = {{(64 - KEY_W){1'b0}}, key} & SORT_MASK;
      shift   = int'(pass) * DIGIT_BITS;
      shifted = masked >> shift;
      return shifted[DIGIT_BITS-1:0];
   endfunction

endpackage

// ----- rtl/core/lsd_radix_sort_unit.sv -----
// LSD radix sort unit: key loading, counting, prefix, scatter and output sequencing.
//
// Usage: keys enter on the req_ channel, one per transfer, with req_is_final set on
// the last key of a set. Up to 64 keys are held; further keys of the set are
// discarded and every result of that set then carries rsp_keys_dropped.
// The final transfer starts the sort and req_stall stays high until the last
// sorted key has left. The keys sit in two single-port-read memories used as
// ping-pong buffers; each pass reads every key once to count digits, walks the
// digit counters once to form start positions and reads every key again to
// scatter it into the other buffer.
// The memory read port, used once per key per phase, sets the time a sort takes.
// Sorted keys then leave in ascending unsigned order, one at a time, since the next
// key is read only once the previous result has been taken; rsp_end_of_run marks
// the last one. A stalled result holds in the output register until its transfer
// completes.
// Reset returns the unit to loading an empty set; memory contents are not cleared.
module lsd_radix_sort_unit
   import lsdrs_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  logic [KEY_W-1:0] req_key_value,
   input  logic             req_is_final,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output logic [KEY_W-1:0] rsp_sorted_value,
   output logic             rsp_end_of_run,
   output logic             rsp_keys_dropped
);

   localparam logic [2:0] S_LOAD   = 3'd0;
   localparam logic [2:0] S_COUNT  = 3'd1;
   localparam logic [2:0] S_PREFIX = 3'd2;
   localparam logic [2:0] S_SCAT   = 3'd3;
   localparam logic [2:0] S_OUT    = 3'd4;

   logic [2:0]            state_ff, state_in;
   logic [CNT_W-1:0]      loaded_ff, loaded_in;
   logic                  overflow_ff, overflow_in;
   logic [PASS_W-1:0]     pass_ff, pass_in;
   logic                  src_ff, src_in;
   logic [CNT_W-1:0]      rd_idx_ff, rd_idx_in;
   logic                  rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0]      cnt_ff [RADIX];
   logic [CNT_W-1:0]      cnt_in [RADIX];
   logic [CNT_W-1:0]      sum_ff, sum_in;
   logic [DIGIT_BITS-1:0] dig_ff, dig_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KEY_W-1:0]      rsp_value_ff, rsp_value_in;
   logic                  rsp_end_ff, rsp_end_in;
   logic                  rsp_drop_ff, rsp_drop_in;

   logic [KEY_W-1:0]      mem0 [CAPACITY];
   logic [KEY_W-1:0]      mem1 [CAPACITY];
   logic [KEY_W-1:0]      mem0_rd_ff;
   logic [KEY_W-1:0]      mem1_rd_ff;
   logic                  mem0_we;
   logic                  mem1_we;
   logic [ADDR_W-1:0]     wr_addr;
   logic [KEY_W-1:0]      wr_data;
   logic [ADDR_W-1:0]     rd_addr;

   logic [KEY_W-1:0]      rd_data;
   logic [DIGIT_BITS-1:0] rd_digit;
   logic                  rd_more;
   logic                  rd_issue;
   logic                  req_accept;
   logic                  rsp_accept;
   logic                  phase_done;

   assign req_stall  = (state_ff != S_LOAD);
   assign req_accept = req_valid && !req_stall;
   assign rsp_accept = rsp_valid_ff && !rsp_stall;
   assign rd_data    = src_ff ? mem1_rd_ff : mem0_rd_ff;
   assign rd_digit   = digit_of(rd_data, pass_ff);
   assign rd_more    = (rd_idx_ff < loaded_ff);
   assign phase_done = !rd_more && !rd_pend_ff;
   assign rd_addr    = rd_idx_ff[ADDR_W-1:0];

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_sorted_value = rsp_value_ff;
   assign rsp_end_of_run   = rsp_end_ff;
   assign rsp_keys_dropped = rsp_drop_ff;

   always_comb begin
      state_in     = state_ff;
      loaded_in    = loaded_ff;
      overflow_in  = overflow_ff;
      pass_in      = pass_ff;
      src_in       = src_ff;
      rd_idx_in    = rd_idx_ff;
      rd_pend_in   = rd_pend_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      dig_in       = dig_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_value_in = rsp_value_ff;
      rsp_end_in   = rsp_end_ff;
      rsp_drop_in  = rsp_drop_ff;
      mem0_we      = 1'b0;
      mem1_we      = 1'b0;
      wr_addr      = loaded_ff[ADDR_W-1:0];
      wr_data      = req_key_value;
      rd_issue     = 1'b0;

      unique case (state_ff)
         S_LOAD: begin
            if (req_accept) begin
               if (loaded_ff < CNT_W'(CAPACITY)) begin
                  mem0_we   = 1'b1;
                  loaded_in = loaded_ff + CNT_W'(1);
               end else begin
                  overflow_in = 1'b1;
               end
               if (req_is_final) begin
                  state_in   = S_COUNT;
                  pass_in    = '0;
                  src_in     = 1'b0;
                  rd_idx_in  = '0;
                  rd_pend_in = 1'b0;
                  for (int j = 0; j < RADIX; j++) begin
                     cnt_in[j] = '0;
                  end
               end
            end
         end
         S_COUNT: begin
            rd_issue   = rd_more;
            rd_pend_in = rd_issue;
            rd_idx_in  = rd_idx_ff + CNT_W'(rd_issue);
            if (rd_pend_ff) begin
               cnt_in[rd_digit] = cnt_ff[rd_digit] + CNT_W'(1);
            end
            if (phase_done) begin
               state_in = S_PREFIX;
               dig_in   = '0;
               sum_in   = '0;
            end
         end
         S_PREFIX: begin
            cnt_in[dig_ff] = sum_ff;
            sum_in         = sum_ff + cnt_ff[dig_ff];
            dig_in         = dig_ff + DIGIT_BITS'(1);
            if (dig_ff == {DIGIT_BITS{1'b1}}) begin
               state_in   = S_SCAT;
               rd_idx_in  = '0;
               rd_pend_in = 1'b0;
            end
         end
         S_SCAT: begin
            rd_issue   = rd_more;
            rd_pend_in = rd_issue;
            rd_idx_in  = rd_idx_ff + CNT_W'(rd_issue);
            if (rd_pend_ff) begin
               wr_addr          = cnt_ff[rd_digit][ADDR_W-1:0];
               wr_data          = rd_data;
               mem0_we          = src_ff;
               mem1_we          = !src_ff;
               cnt_in[rd_digit] = cnt_ff[rd_digit] + CNT_W'(1);
            end
            if (phase_done) begin
               src_in     = !src_ff;
               rd_idx_in  = '0;
               rd_pend_in = 1'b0;
               for (int j = 0; j < RADIX; j++) begin
                  cnt_in[j] = '0;
               end
               if (pass_ff == PASS_W'(PASSES - 1)) begin
                  state_in = S_OUT;
               end else begin
                  pass_in  = pass_ff + PASS_W'(1);
                  state_in = S_COUNT;
               end
            end
         end
         S_OUT: begin
            rd_issue   = rd_more && !rd_pend_ff && !rsp_valid_ff;
            rd_pend_in = rd_issue;
            rd_idx_in  = rd_idx_ff + CNT_W'(rd_issue);
            if (rd_pend_ff) begin
               rsp_valid_in = 1'b1;
               rsp_value_in = rd_data;
               rsp_end_in   = !rd_more;
               rsp_drop_in  = overflow_ff;
            end else if (rsp_accept) begin
               rsp_valid_in = 1'b0;
               if (rsp_end_ff) begin
                  state_in    = S_LOAD;
                  loaded_in   = '0;
                  overflow_in = 1'b0;
               end
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_LOAD;
         loaded_ff    <= '0;
         overflow_ff  <= 1'b0;
         pass_ff      <= '0;
         src_ff       <= 1'b0;
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         sum_ff       <= '0;
         dig_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int j = 0; j < RADIX; j++) begin
            cnt_ff[j] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         loaded_ff    <= loaded_in;
         overflow_ff  <= overflow_in;
         pass_ff      <= pass_in;
         src_ff       <= src_in;
         rd_idx_ff    <= rd_idx_in;
         rd_pend_ff   <= rd_pend_in;
         sum_ff       <= sum_in;
         dig_ff       <= dig_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_value_ff <= rsp_value_in;
      rsp_end_ff   <= rsp_end_in;
      rsp_drop_ff  <= rsp_drop_in;
   end

   always_ff @(posedge clock) begin
      if (mem0_we) begin
         mem0[wr_addr] <= wr_data;
      end
      mem0_rd_ff <= mem0[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (mem1_we) begin
         mem1[wr_addr] <= wr_data;
      end
      mem1_rd_ff <= mem1[rd_addr];
   end

   a_rsp_only_in_output : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == S_OUT))
      else $error("Result presented outside the output phase.");

   a_loaded_in_range : assert property (@(posedge clock) disable iff (reset)
      loaded_ff <= CNT_W'(CAPACITY))
      else $error("Loaded key count exceeds the capacity.");

   a_scatter_in_set : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAT && rd_pend_ff) |-> (cnt_ff[rd_digit] < loaded_ff))
      else $error("Scatter position lies beyond the loaded set.");

   a_return_to_load : assert property (@(posedge clock) disable iff (reset)
      (rsp_accept && rsp_end_ff) |=> (state_ff == S_LOAD && loaded_ff == '0
                                      && !overflow_ff))
      else $error("Unit did not return to an empty set after the last transfer.");

endmodule
